// ----- hw/rtl/tcp5t_pkg.sv -----
package tcp5t_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W = POS_W + 1;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'h06;
  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [3:0] DOFF_REL_POS = 4'd12;

  localparam logic [31:0] RST_SRC_ADDR = 32'h7F00_0001;
  localparam logic [31:0] RST_DST_ADDR = 32'h7F00_0001;
  localparam logic [15:0] RST_SRC_PORT = 16'd54321;
  localparam logic [15:0] RST_DST_PORT = 16'd54321;
  localparam logic [7:0] RST_PROTOCOL = 8'd6;

  typedef enum logic [2:0] {
    VERDICT_MATCH       = 3'd0,
    VERDICT_NOT_IPV4    = 3'd1,
    VERDICT_BAD_IP_HDR  = 3'd2,
    VERDICT_NOT_TCP     = 3'd3,
    VERDICT_BAD_TCP_HDR = 3'd4,
    VERDICT_MISMATCH    = 3'd5,
    VERDICT_TRUNCATED   = 3'd6
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ADDR = 3'd0,
    CFG_DST_ADDR = 3'd1,
    CFG_SRC_PORT = 3'd2,
    CFG_DST_PORT = 3'd3,
    CFG_PROTOCOL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] payload_offset;
    logic [5:0] tcp_hdr_bytes;
    logic [5:0] ip_hdr_bytes;
    verdict_t   verdict;
  } result_t;

endpackage

// ----- hw/rtl/tcp_five_tuple_filter.sv -----
// Five-tuple filter for IPv4/TCP frames. Frame bytes come in on the slave stream one per
// cycle in wire order, with tlast on the final byte; each frame yields exactly one verdict
// on the master stream, registered in the cycle after its last byte is taken. The input runs
// at one byte per clock and is held off only while a verdict waits in the output register
// and the downstream side is not ready. The match tuple is written through the cfg port
// (0 source address, 1 destination address, 2 source port, 3 destination port, 4 protocol)
// while no frame is in flight. No clearing pass is needed after reset.
module tcp_five_tuple_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tcp5t_pkg::BYTE_W-1:0]          s_axis_tdata,  // frame_byte[7:0]
  input  logic                                  s_axis_tlast,  // end_of_frame
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // verdict[2:0], ip_hdr_bytes[8:3], tcp_hdr_bytes[14:9], payload_offset[22:15], zero[23]
  output logic [tcp5t_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [tcp5t_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcp5t_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tcp5t_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES - 1);

  logic [31:0] match_src_addr;
  logic [31:0] match_dst_addr;
  logic [15:0] match_src_port;
  logic [15:0] match_dst_port;
  logic [7:0]  match_protocol;

  logic [POS_W-1:0] byte_position;
  logic [15:0]      eth_type;
  logic [3:0]       ip_header_len;
  logic [7:0]       ip_protocol;
  logic [31:0]      src_addr_seen;
  logic [31:0]      dst_addr_seen;
  logic [15:0]      src_port_seen;
  logic [15:0]      dst_port_seen;
  logic [3:0]       tcp_data_offset;

  logic [15:0] eth_type_next;
  logic [3:0]  ip_header_len_next;
  logic [7:0]  ip_protocol_next;
  logic [31:0] src_addr_seen_next;
  logic [31:0] dst_addr_seen_next;
  logic [15:0] src_port_seen_next;
  logic [15:0] dst_port_seen_next;
  logic [3:0]  tcp_data_offset_next;

  logic             out_valid;
  result_t          out_data;
  result_t          result_next;
  logic             in_accept;

  logic [6:0]       tcp_start;
  logic [POS_W-1:0] tcp_rel;
  logic             in_tcp;
  logic [LEN_W-1:0] frame_len;
  logic [5:0]       ipb;
  logic [5:0]       tcpb;
  logic [7:0]       hdr_total;
  logic             tuple_ok;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data};

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_src_addr <= RST_SRC_ADDR;
      match_dst_addr <= RST_DST_ADDR;
      match_src_port <= RST_SRC_PORT;
      match_dst_port <= RST_DST_PORT;
      match_protocol <= RST_PROTOCOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_ADDR: match_src_addr <= cfg_data;
        CFG_DST_ADDR: match_dst_addr <= cfg_data;
        CFG_SRC_PORT: match_src_port <= cfg_data[15:0];
        CFG_DST_PORT: match_dst_port <= cfg_data[15:0];
        CFG_PROTOCOL: match_protocol <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // header field capture
  always_comb begin
    eth_type_next        = eth_type;
    ip_header_len_next   = ip_header_len;
    ip_protocol_next     = ip_protocol;
    src_addr_seen_next   = src_addr_seen;
    dst_addr_seen_next   = dst_addr_seen;
    src_port_seen_next   = src_port_seen;
    dst_port_seen_next   = dst_port_seen;
    tcp_data_offset_next = tcp_data_offset;

    if (byte_position == POS_W'(12) || byte_position == POS_W'(13)) begin
      eth_type_next = {eth_type[7:0], s_axis_tdata};
    end else if (byte_position == POS_W'(14)) begin
      ip_header_len_next = s_axis_tdata[3:0];
    end else if (byte_position == POS_W'(23)) begin
      ip_protocol_next = s_axis_tdata;
    end else if (byte_position >= POS_W'(26) && byte_position <= POS_W'(29)) begin
      src_addr_seen_next = {src_addr_seen[23:0], s_axis_tdata};
    end else if (byte_position >= POS_W'(30) && byte_position <= POS_W'(33)) begin
      dst_addr_seen_next = {dst_addr_seen[23:0], s_axis_tdata};
    end

    tcp_start = ETH_HDR_BYTES + {1'b0, ip_header_len, 2'b00};
    in_tcp = (ip_header_len >= MIN_HDR_WORDS) && (byte_position >= POS_W'(15)) &&
             (byte_position >= POS_W'(tcp_start));
    tcp_rel = byte_position - POS_W'(tcp_start);
    if (in_tcp) begin
      if (tcp_rel == POS_W'(0) || tcp_rel == POS_W'(1)) begin
        src_port_seen_next = {src_port_seen[7:0], s_axis_tdata};
      end else if (tcp_rel == POS_W'(2) || tcp_rel == POS_W'(3)) begin
        dst_port_seen_next = {dst_port_seen[7:0], s_axis_tdata};
      end else if (tcp_rel == POS_W'(DOFF_REL_POS)) begin
        tcp_data_offset_next = s_axis_tdata[7:4];
      end
    end
  end

  // verdict on the last byte
  always_comb begin
    frame_len = {1'b0, byte_position} + LEN_W'(1);
    ipb = {ip_header_len_next, 2'b00};
    tcpb = {tcp_data_offset_next, 2'b00};
    hdr_total = 8'(ETH_HDR_BYTES) + 8'(ipb) + 8'(tcpb);
    tuple_ok = (src_addr_seen_next == match_src_addr) &&
               (dst_addr_seen_next == match_dst_addr) &&
               (ip_protocol_next == match_protocol) &&
               (src_port_seen_next == match_src_port) &&
               (dst_port_seen_next == match_dst_port);

    result_next.ip_hdr_bytes = ipb;
    result_next.tcp_hdr_bytes = tcpb;
    priority if (frame_len < LEN_W'(ETH_HDR_BYTES)) begin
      result_next.verdict = VERDICT_TRUNCATED;
    end else if (eth_type_next != ETHERTYPE_IPV4) begin
      result_next.verdict = VERDICT_NOT_IPV4;
    end else if (frame_len < LEN_W'(ETH_HDR_BYTES) + LEN_W'(1)) begin
      result_next.verdict = VERDICT_TRUNCATED;
    end else if (ipb < MIN_HDR_BYTES) begin
      result_next.verdict = VERDICT_BAD_IP_HDR;
    end else if (frame_len < LEN_W'(ETH_HDR_BYTES) + LEN_W'(ipb)) begin
      result_next.verdict = VERDICT_TRUNCATED;
    end else if (ip_protocol_next != PROTO_TCP) begin
      result_next.verdict = VERDICT_NOT_TCP;
    end else if (frame_len < LEN_W'(ETH_HDR_BYTES) + LEN_W'(ipb) + LEN_W'(13)) begin
      result_next.verdict = VERDICT_TRUNCATED;
    end else if (tcpb < MIN_HDR_BYTES) begin
      result_next.verdict = VERDICT_BAD_TCP_HDR;
    end else if (frame_len < LEN_W'(hdr_total)) begin
      result_next.verdict = VERDICT_TRUNCATED;
    end else if (!tuple_ok) begin
      result_next.verdict = VERDICT_MISMATCH;
    end else begin
      result_next.verdict = VERDICT_MATCH;
    end

    if (result_next.verdict == VERDICT_MATCH || result_next.verdict == VERDICT_MISMATCH) begin
      result_next.payload_offset = hdr_total;
    end else begin
      result_next.payload_offset = 8'd0;
    end
  end

  // per-frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      eth_type        <= '0;
      ip_header_len   <= '0;
      ip_protocol     <= '0;
      src_addr_seen   <= '0;
      dst_addr_seen   <= '0;
      src_port_seen   <= '0;
      dst_port_seen   <= '0;
      tcp_data_offset <= '0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        byte_position   <= '0;
        eth_type        <= '0;
        ip_header_len   <= '0;
        ip_protocol     <= '0;
        src_addr_seen   <= '0;
        dst_addr_seen   <= '0;
        src_port_seen   <= '0;
        dst_port_seen   <= '0;
        tcp_data_offset <= '0;
      end else begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
        eth_type        <= eth_type_next;
        ip_header_len   <= ip_header_len_next;
        ip_protocol     <= ip_protocol_next;
        src_addr_seen   <= src_addr_seen_next;
        dst_addr_seen   <= dst_addr_seen_next;
        src_port_seen   <= src_port_seen_next;
        dst_port_seen   <= dst_port_seen_next;
        tcp_data_offset <= tcp_data_offset_next;
      end
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tlast) begin
      out_data <= result_next;
    end
  end

  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && s_axis_tlast))
    else $error("verdict without a last byte");

  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_axis_tlast |=> byte_position == '0 && ip_header_len == '0)
    else $error("frame state not cleared after last byte");

  a_payload_only_tcp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_offset != 8'd0 |->
      out_data.verdict == VERDICT_MATCH || out_data.verdict == VERDICT_MISMATCH)
    else $error("payload offset on a rejected frame");

  a_match_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict == VERDICT_MATCH |->
      out_data.ip_hdr_bytes >= MIN_HDR_BYTES && out_data.tcp_hdr_bytes >= MIN_HDR_BYTES)
    else $error("match with short header");

endmodule

// ----- tb/tcp_five_tuple_filter_tb.sv -----
module tcp_five_tuple_filter_tb;
  import tcp5t_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } stream_byte_t;

  typedef struct {
    logic [15:0] etype;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    int          len;
  } frame_spec_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SRC_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcp_five_tuple_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // frame_byte[7:0]
    .s_axis_tlast  (s_axis_tlast),   // end_of_frame
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // verdict[2:0], ip_hdr_bytes[8:3], tcp_hdr_bytes[14:9], payload_offset[22:15], zero[23]
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // match tuple as the block should hold it
  logic [31:0] tuple_src_addr = RST_SRC_ADDR;
  logic [31:0] tuple_dst_addr = RST_DST_ADDR;
  logic [15:0] tuple_src_port = RST_SRC_PORT;
  logic [15:0] tuple_dst_port = RST_DST_PORT;
  logic [7:0]  tuple_protocol = RST_PROTOCOL;

  // per-frame capture state
  logic [POS_W-1:0] fr_pos = '0;
  logic [15:0] fr_etype = '0;
  logic [3:0]  fr_ihl = '0;
  logic [7:0]  fr_proto = '0;
  logic [31:0] fr_src = '0;
  logic [31:0] fr_dst = '0;
  logic [15:0] fr_sport = '0;
  logic [15:0] fr_dport = '0;
  logic [3:0]  fr_doff = '0;

  stream_byte_t pending_bytes[$];
  result_t expected_verdicts[$];
  int bytes_queued = 0;
  int mismatch_count = 0;
  int verdicts_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stuck_cycles = 0;
  bit steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic filter_byte(input logic [7:0] b, input logic eof);
    int pos, len, ipb, tcpb, tcp_start, r;
    verdict_t v;
    result_t res;
    pos = int'(fr_pos);
    if (pos == 12 || pos == 13) fr_etype = {fr_etype[7:0], b};
    else if (pos == 14) fr_ihl = b[3:0];
    else if (pos == 23) fr_proto = b;
    else if (pos >= 26 && pos <= 29) fr_src = {fr_src[23:0], b};
    else if (pos >= 30 && pos <= 33) fr_dst = {fr_dst[23:0], b};
    if (fr_ihl >= MIN_HDR_WORDS && pos >= 15) begin
      tcp_start = int'(ETH_HDR_BYTES) + 4 * int'(fr_ihl);
      if (pos >= tcp_start) begin
        r = pos - tcp_start;
        if (r == 0 || r == 1) fr_sport = {fr_sport[7:0], b};
        else if (r == 2 || r == 3) fr_dport = {fr_dport[7:0], b};
        else if (r == int'(DOFF_REL_POS)) fr_doff = b[7:4];
      end
    end
    if (!eof) begin
      if (pos < MAX_FRAME_BYTES - 1) fr_pos = fr_pos + 1'b1;
      return;
    end
    len = pos + 1;
    ipb = 4 * int'(fr_ihl);
    tcpb = 4 * int'(fr_doff);
    if (len < int'(ETH_HDR_BYTES)) v = VERDICT_TRUNCATED;
    else if (fr_etype != ETHERTYPE_IPV4) v = VERDICT_NOT_IPV4;
    else if (len < int'(ETH_HDR_BYTES) + 1) v = VERDICT_TRUNCATED;
    else if (ipb < int'(MIN_HDR_BYTES)) v = VERDICT_BAD_IP_HDR;
    else if (len < int'(ETH_HDR_BYTES) + ipb) v = VERDICT_TRUNCATED;
    else if (fr_proto != PROTO_TCP) v = VERDICT_NOT_TCP;
    else if (len < int'(ETH_HDR_BYTES) + ipb + 13) v = VERDICT_TRUNCATED;
    else if (tcpb < int'(MIN_HDR_BYTES)) v = VERDICT_BAD_TCP_HDR;
    else if (len < int'(ETH_HDR_BYTES) + ipb + tcpb) v = VERDICT_TRUNCATED;
    else if (fr_src != tuple_src_addr || fr_dst != tuple_dst_addr ||
             fr_proto != tuple_protocol || fr_sport != tuple_src_port ||
             fr_dport != tuple_dst_port) v = VERDICT_MISMATCH;
    else v = VERDICT_MATCH;
    if (pos < 14) ipb = 0;
    res.verdict = v;
    res.ip_hdr_bytes = 6'(ipb);
    res.tcp_hdr_bytes = 6'(tcpb);
    res.payload_offset = (v == VERDICT_MATCH || v == VERDICT_MISMATCH) ?
                         8'(int'(ETH_HDR_BYTES) + ipb + tcpb) : 8'd0;
    expected_verdicts.push_back(res);
    fr_pos = '0;
    fr_etype = '0;
    fr_ihl = '0;
    fr_proto = '0;
    fr_src = '0;
    fr_dst = '0;
    fr_sport = '0;
    fr_dport = '0;
    fr_doff = '0;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at verdict %0d: %s got %0d want %0d", verdicts_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_verdict(input logic [OUT_DATA_W-1:0] word);
    result_t got, want;
    got = result_t'(word[OUT_DATA_W-2:0]);
    if (expected_verdicts.size() == 0) begin
      flag_mismatch("unexpected verdict", int'(word), -1);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.verdict !== want.verdict)
      flag_mismatch("verdict", int'(got.verdict), int'(want.verdict));
    if (got.ip_hdr_bytes !== want.ip_hdr_bytes)
      flag_mismatch("ip_hdr_bytes", int'(got.ip_hdr_bytes), int'(want.ip_hdr_bytes));
    if (got.tcp_hdr_bytes !== want.tcp_hdr_bytes)
      flag_mismatch("tcp_hdr_bytes", int'(got.tcp_hdr_bytes), int'(want.tcp_hdr_bytes));
    if (got.payload_offset !== want.payload_offset)
      flag_mismatch("payload_offset", int'(got.payload_offset), int'(want.payload_offset));
    if (word[OUT_DATA_W-1] !== 1'b0)
      flag_mismatch("pad bit", int'(word[OUT_DATA_W-1]), 0);
  endtask

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin : frame_driver
    stream_byte_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) filter_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.data;
          s_axis_tlast <= nxt.eof;
          gap_left = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : verdict_monitor
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_verdict(m_axis_tdata);
        verdicts_seen++;
        // long hold while the directed frames are still streaming in
        if (verdicts_seen == 10) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_stall();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else if (pending_bytes.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int header_len(input frame_spec_t f);
    return int'(ETH_HDR_BYTES) + 4 * int'(f.ihl) + 4 * int'(f.doff);
  endfunction

  function automatic frame_spec_t matching_frame();
    frame_spec_t f;
    f.etype = ETHERTYPE_IPV4;
    f.ver = 4'd4;
    f.ihl = MIN_HDR_WORDS;
    f.doff = MIN_HDR_WORDS;
    f.proto = PROTO_TCP;
    f.src = tuple_src_addr;
    f.dst = tuple_dst_addr;
    f.sport = tuple_src_port;
    f.dport = tuple_dst_port;
    f.len = header_len(f);
    return f;
  endfunction

  task automatic queue_frame(input frame_spec_t f);
    int tcp_start, r;
    logic [7:0] b;
    tcp_start = int'(ETH_HDR_BYTES) + 4 * int'(f.ihl);
    for (int p = 0; p < f.len; p++) begin
      b = 8'($urandom);
      if (p == 12) b = f.etype[15:8];
      else if (p == 13) b = f.etype[7:0];
      else if (p == 14) b = {f.ver, f.ihl};
      else if (p == 23) b = f.proto;
      else if (p >= 26 && p <= 29) b = f.src[8*(29-p) +: 8];
      else if (p >= 30 && p <= 33) b = f.dst[8*(33-p) +: 8];
      else if (f.ihl >= MIN_HDR_WORDS && p >= tcp_start) begin
        r = p - tcp_start;
        if (r < 2) b = f.sport[8*(1-r) +: 8];
        else if (r < 4) b = f.dport[8*(3-r) +: 8];
        else if (r == int'(DOFF_REL_POS)) b = {f.doff, b[3:0]};
      end
      pending_bytes.push_back('{data: b, eof: (p == f.len - 1)});
    end
    bytes_queued += f.len;
  endtask

  task automatic queue_fill_frame(input logic [7:0] b, input int len);
    for (int p = 0; p < len; p++) pending_bytes.push_back('{data: b, eof: (p == len - 1)});
    bytes_queued += len;
  endtask

  task automatic queue_random_frame();
    frame_spec_t f;
    int pick;
    f = matching_frame();
    if ($urandom_range(0, 9) < 3) f.ihl = 4'($urandom_range(5, 15));
    if ($urandom_range(0, 9) < 3) f.doff = 4'($urandom_range(5, 15));
    if ($urandom_range(0, 4) == 0) f.ver = 4'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) f.proto = 8'($urandom);
    else if (pick == 1) f.proto = tuple_protocol;
    if ($urandom_range(0, 4) == 0) f.src = $urandom;
    if ($urandom_range(0, 4) == 0) f.dst = $urandom;
    if ($urandom_range(0, 4) == 0) f.sport = 16'($urandom);
    if ($urandom_range(0, 4) == 0) f.dport = 16'($urandom);
    f.len = header_len(f) +
            (($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 40));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      f.len = $urandom_range(1, f.len - 1);
    end else if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: f.etype = 16'($urandom);
        1: f.ihl = 4'($urandom_range(0, 4));
        2: f.proto = 8'($urandom);
        default: f.doff = 4'($urandom_range(0, 4));
      endcase
    end else if (pick < 40) begin
      f.etype = ($urandom_range(0, 1) == 0) ? ETHERTYPE_IPV4 : 16'($urandom);
      f.ver = 4'($urandom);
      f.ihl = 4'($urandom);
      f.doff = 4'($urandom);
      f.proto = 8'($urandom);
      f.src = $urandom;
      f.dst = $urandom;
      f.sport = 16'($urandom);
      f.dport = 16'($urandom);
      f.len = $urandom_range(1, 80);
    end
    queue_frame(f);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase();
    int start_bytes, frames;
    start_bytes = bytes_queued;
    frames = 0;
    while (bytes_queued - start_bytes < 90 || frames < 1) begin
      queue_random_frame();
      frames++;
    end
    wait_idle();
  endtask

  task automatic write_tuple(input logic [31:0] src, input logic [31:0] dst,
                             input logic [31:0] sport, input logic [31:0] dport,
                             input logic [31:0] proto);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SRC_ADDR;
    cfg_data <= src;
    @(posedge clk);
    cfg_index <= CFG_DST_ADDR;
    cfg_data <= dst;
    @(posedge clk);
    cfg_index <= CFG_SRC_PORT;
    cfg_data <= sport;
    @(posedge clk);
    cfg_index <= CFG_DST_PORT;
    cfg_data <= dport;
    @(posedge clk);
    cfg_index <= CFG_PROTOCOL;
    cfg_data <= proto;
    @(posedge clk);
    cfg_we <= 1'b0;
    tuple_src_addr = src;
    tuple_dst_addr = dst;
    tuple_src_port = sport[15:0];
    tuple_dst_port = dport[15:0];
    tuple_protocol = proto[7:0];
  endtask

  initial begin
    frame_spec_t f;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    f = matching_frame();
    queue_frame(f);
    f.ihl = 4'd15;
    f.doff = 4'd15;
    f.len = header_len(f) + 6;
    queue_frame(f);
    f = matching_frame();
    f.ver = 4'd6;
    queue_frame(f);
    f = matching_frame();
    f.etype = 16'h86DD;
    queue_frame(f);
    f = matching_frame();
    f.len = 1;
    queue_frame(f);
    f.len = 13;
    queue_frame(f);
    f.len = 14;
    queue_frame(f);
    f.etype = 16'h0806;
    queue_frame(f);
    f = matching_frame();
    f.ihl = 4'd4;
    queue_frame(f);
    f.ihl = 4'd0;
    queue_frame(f);
    f = matching_frame();
    f.len = 33;
    queue_frame(f);
    f.len = header_len(f);
    f.proto = 8'd17;
    queue_frame(f);
    f = matching_frame();
    f.len = 14 + 20 + 12;
    queue_frame(f);
    f.len = 14 + 20 + 13;
    queue_frame(f);
    f = matching_frame();
    f.doff = 4'd4;
    queue_frame(f);
    f.doff = 4'd0;
    queue_frame(f);
    f = matching_frame();
    f.doff = 4'd15;
    f.len = header_len(f) - 1;
    queue_frame(f);
    f = matching_frame();
    f.src = f.src ^ 32'h1;
    queue_frame(f);
    f = matching_frame();
    f.dst = f.dst ^ 32'h8000_0000;
    queue_frame(f);
    f = matching_frame();
    f.sport = f.sport ^ 16'h1;
    queue_frame(f);
    f = matching_frame();
    f.dport = f.dport ^ 16'h8000;
    queue_frame(f);
    queue_fill_frame(8'hFF, 60);
    queue_fill_frame(8'h00, 60);
    wait_idle();
    run_random_phase();

    write_tuple('0, '0, '0, '0, '0);
    run_random_phase();
    write_tuple('1, '1, '1, '1, '1);
    run_random_phase();
    write_tuple($urandom, $urandom, $urandom, $urandom, 32'(PROTO_TCP));
    run_random_phase();
    steady_flow = 1'b1;
    write_tuple($urandom, $urandom, $urandom, $urandom, 32'(PROTO_TCP));
    run_random_phase();
    steady_flow = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tcp5t_pkg.sv
hw/rtl/tcp_five_tuple_filter.sv
tb/tcp_five_tuple_filter_tb.sv
